@@ design/clw_pkg.sv @@
// Package for the character LCD text writer: shared types, codes and constants.
// Used by clw_front, clw_queue, clw_back and char_lcd_text_writer.
package clw_pkg;

  localparam int COL_W      = 6;
  localparam int ROW_W      = 3;
  localparam int BYTE_W     = 8;
  localparam int NIBBLE_W   = 4;
  localparam int WAIT_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam int MAX_ROWS_DEFAULT = 4;

  localparam logic [COL_W-1:0] COLUMNS_RESET = 6'd16;
  localparam logic [ROW_W-1:0] ROWS_RESET    = 3'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'd1;

  localparam logic [BYTE_W-1:0] CMD_SET_ADDR = 8'h80;
  localparam logic [BYTE_W-1:0] CHAR_LF      = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR      = 8'h0D;
  localparam logic [BYTE_W-1:0] CMD_SLOW_LIM = 8'h04;

  localparam logic [WAIT_W-1:0] WAIT_NONE     = 2'd0;
  localparam logic [WAIT_W-1:0] WAIT_DATA     = 2'd1;
  localparam logic [WAIT_W-1:0] WAIT_CMD      = 2'd2;
  localparam logic [WAIT_W-1:0] WAIT_CMD_SLOW = 2'd3;

  localparam logic [BYTE_W-1:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_TEXT   = 2'd0,
    ACT_CURSOR = 2'd1,
    ACT_CMD    = 2'd2,
    ACT_DATA   = 2'd3
  } action_t;

  // One accepted item, reduced to at most two bytes. The optional first byte
  // is always a cursor address command.
  typedef struct packed {
    logic              has_first;
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
    logic              second_is_data;
  } job_t;

  function automatic logic [ROW_W-1:0] row_wrap(input logic [ROW_W-1:0] row,
                                                input logic [ROW_W-1:0] lim);
    return (row >= lim) ? '0 : row;
  endfunction

  function automatic logic [BYTE_W-1:0] cursor_addr(input logic [COL_W-1:0] col,
                                                    input logic [ROW_W-1:0] row);
    logic [BYTE_W-1:0] sum;
    sum = BYTE_W'(col) + ROW_BASE[row[1:0]];
    return CMD_SET_ADDR | sum;
  endfunction

endpackage

@@ design/clw_front.sv @@
// Front part of the character LCD text writer: holds the cursor and the
// configuration registers and turns each item into a byte job. Uses clw_pkg.
module clw_front #(
  parameter int MAX_ROWS = clw_pkg::MAX_ROWS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [clw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                         accept,
  input  logic [1:0]                   action,
  input  logic [clw_pkg::BYTE_W-1:0]   byte_value,
  input  logic [clw_pkg::COL_W-1:0]    col_in,
  input  logic [clw_pkg::ROW_W-1:0]    row_in,
  output clw_pkg::job_t                job
);
  import clw_pkg::*;

  logic [COL_W-1:0] columns;
  logic [ROW_W-1:0] rows;
  logic [COL_W-1:0] cursor_col, cursor_col_next;
  logic [ROW_W-1:0] cursor_row, cursor_row_next;

  logic [ROW_W-1:0] lim;
  logic             wrap;
  logic [ROW_W-1:0] row_w, row_lf, row_cr, row_set;
  logic [COL_W-1:0] col_c;
  logic [ROW_W-1:0] row_c;
  action_t          act;

  assign act  = action_t'(action);
  assign lim  = (rows > ROW_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : rows;
  assign wrap = (cursor_col >= columns);

  // Column wrap comes first; newline and carriage return then see its result.
  assign row_w   = row_wrap(cursor_row + 3'd1, lim);
  assign col_c   = wrap ? '0 : cursor_col;
  assign row_c   = wrap ? row_w : cursor_row;
  assign row_lf  = row_wrap(row_c + 3'd1, lim);
  assign row_cr  = row_wrap(row_c, lim);
  assign row_set = row_wrap(row_in, lim);

  always_comb begin
    job.has_first      = 1'b0;
    job.first_byte     = cursor_addr('0, row_w);
    job.second_byte    = byte_value;
    job.second_is_data = 1'b0;
    cursor_col_next    = cursor_col;
    cursor_row_next    = cursor_row;
    case (act)
      ACT_TEXT: begin
        job.has_first = wrap;
        if (byte_value == CHAR_LF) begin
          job.second_byte = cursor_addr(col_c, row_lf);
          cursor_col_next = col_c;
          cursor_row_next = row_lf;
        end else if (byte_value == CHAR_CR) begin
          job.second_byte = cursor_addr('0, row_cr);
          cursor_col_next = '0;
          cursor_row_next = row_cr;
        end else begin
          job.second_is_data = 1'b1;
          cursor_col_next    = col_c + 6'd1;
          cursor_row_next    = row_c;
        end
      end
      ACT_CURSOR: begin
        job.second_byte = cursor_addr(col_in, row_set);
        cursor_col_next = col_in;
        cursor_row_next = row_set;
      end
      ACT_CMD: begin
        job.second_is_data = 1'b0;
      end
      ACT_DATA: begin
        job.second_is_data = 1'b1;
      end
      default: begin
        job.second_is_data = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      columns    <= COLUMNS_RESET;
      rows       <= ROWS_RESET;
      cursor_col <= '0;
      cursor_row <= '0;
    end else begin
      if (cfg_write && cfg_index == REG_COLUMNS) begin
        columns <= cfg_data;
      end
      if (cfg_write && cfg_index == REG_ROWS) begin
        rows <= cfg_data[ROW_W-1:0];
      end
      if (accept) begin
        cursor_col <= cursor_col_next;
        cursor_row <= cursor_row_next;
      end
    end
  end

endmodule

@@ design/clw_queue.sv @@
// Short job queue between the front and back parts of the text writer.
// Uses clw_pkg for the job type and depth.
module clw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  clw_pkg::job_t wr_job,
  input  logic          rd,
  output clw_pkg::job_t rd_job,
  output logic          full,
  output logic          empty
);
  import clw_pkg::*;

  job_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_wr, do_rd;

  assign full   = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr && !full;
  assign do_rd  = rd && !empty;
  assign rd_job = slots[rd_ptr];

  function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
    return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_rd) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_full_and_empty: assert property (@(posedge clk) disable iff (rst)
    !(full && empty))
    else $error("queue reports full and empty together");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not rise on a write");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (do_rd && !do_wr) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not fall on a read");
`endif

endmodule

@@ design/clw_back.sv @@
// Back part of the text writer: splits each byte job into nibble beats,
// high nibble first, with register select and wait time. Uses clw_pkg.
module clw_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  clw_pkg::job_t                q_job,
  output logic                         q_rd,
  input  logic                         pop,
  output logic                         empty,
  output logic [clw_pkg::NIBBLE_W-1:0] nibble,
  output logic                         reg_select,
  output logic [clw_pkg::WAIT_W-1:0]   wait_ms,
  output logic                         last
);
  import clw_pkg::*;

  job_t              cur;
  logic              valid;
  logic [1:0]        step;
  logic              done;
  logic              load;
  logic [BYTE_W-1:0] cur_byte;
  logic              cur_data;
  logic              high_half;

  // Steps 0 and 1 carry the address byte, steps 2 and 3 the second byte.
  assign done = valid && pop && (step == 2'd3);
  assign load = (!valid || done) && !q_empty;
  assign q_rd = load;

  assign cur_byte  = step[1] ? cur.second_byte : cur.first_byte;
  assign cur_data  = step[1] ? cur.second_is_data : 1'b0;
  assign high_half = !step[0];

  assign empty      = !valid;
  assign nibble     = high_half ? cur_byte[7:4] : cur_byte[3:0];
  assign reg_select = cur_data;
  assign last       = (step == 2'd3);

  always_comb begin
    if (high_half) begin
      wait_ms = WAIT_NONE;
    end else if (cur_data) begin
      wait_ms = WAIT_DATA;
    end else if (cur_byte < CMD_SLOW_LIM) begin
      wait_ms = WAIT_CMD_SLOW;
    end else begin
      wait_ms = WAIT_CMD;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      step  <= 2'd0;
    end else if (load) begin
      valid <= 1'b1;
      step  <= q_job.has_first ? 2'd0 : 2'd2;
    end else if (done) begin
      valid <= 1'b0;
    end else if (valid && pop) begin
      step <= step + 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_item_continues: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last) |=> (!empty && step == $past(step) + 2'd1))
    else $error("nibble beat of an item was dropped");

  a_high_then_low: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && wait_ms == WAIT_NONE) |=> (wait_ms != WAIT_NONE && !last == 1'b0
      || wait_ms != WAIT_NONE))
    else $error("high nibble not followed by its low nibble");

  a_data_only_second: assert property (@(posedge clk) disable iff (rst)
    (!empty && reg_select) |-> step[1])
    else $error("data register selected on an address byte");
`endif

endmodule

@@ design/char_lcd_text_writer.sv @@
// Character LCD text writer on a 4-bit bus. With the back part idle, an accepted item is
// queued, then loaded into the back part's current job register, whose first beat drives
// the result ports. Throughput: one item per cycle in while the two-entry queue has room,
// one nibble beat per cycle out while pop is asserted; an item yields 2 or 4 beats, so
// the single nibble output sets the sustained item rate. Synchronous active-high reset:
// cursor at column 0 row 0, columns 16, rows 2, queue and output empty.
module char_lcd_text_writer #(
  parameter int MAX_ROWS = clw_pkg::MAX_ROWS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [clw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     action,
  input  logic [clw_pkg::BYTE_W-1:0]     byte_value,
  input  logic [clw_pkg::COL_W-1:0]      col_in,
  input  logic [clw_pkg::ROW_W-1:0]      row_in,
  output logic                           empty,
  input  logic                           pop,
  output logic [clw_pkg::NIBBLE_W-1:0]   nibble,
  output logic                           reg_select,
  output logic [clw_pkg::WAIT_W-1:0]     wait_ms,
  output logic                           last
);
  import clw_pkg::*;

  logic accept;
  job_t front_job;
  job_t q_job;
  logic q_rd;
  logic q_empty;

  assign accept = push && !full;

  clw_front #(
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .action     (action),
    .byte_value (byte_value),
    .col_in     (col_in),
    .row_in     (row_in),
    .job        (front_job)
  );

  clw_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (accept),
    .wr_job (front_job),
    .rd     (q_rd),
    .rd_job (q_job),
    .full   (full),
    .empty  (q_empty)
  );

  clw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_job      (q_job),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .nibble     (nibble),
    .reg_select (reg_select),
    .wait_ms    (wait_ms),
    .last       (last)
  );

endmodule
